// ----- src/rect_pair_separating_axis_test_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the rectangle pair separating axis test unit
// Checks compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RECT_PAIR_SEPARATING_AXIS_TEST_UNIT_MACROS_SVH
`define RECT_PAIR_SEPARATING_AXIS_TEST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define RPSAT_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rpsat assertion failed");
// Condition must never be true outside reset.
`define RPSAT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rpsat forbidden condition seen");
`else
`define RPSAT_ASSERT(name, clk, rst, prop)
`define RPSAT_NEVER(name, clk, rst, cond)
`endif
`endif

// ----- src/rpsat_pkg.sv -----
// ---------------------------------------------------------------------------
// rpsat_pkg
// Shared constants, microcode format and control structs of the unit.
// ---------------------------------------------------------------------------
package rpsat_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int SHAPE_CORNERS   = 4;
  localparam int TOTAL_CORNERS   = 2 * SHAPE_CORNERS;
  localparam int NUM_AXES        = 4;
  localparam int CORNER_IDX_W    = $clog2(TOTAL_CORNERS);
  localparam int AXIS_W          = $clog2(NUM_AXES);
  localparam int UPC_W           = 3;

  // Datapath operation of one microcode step
  typedef enum logic [2:0] {
    UOP_FROM,
    UOP_NEXT,
    UOP_AXIS,
    UOP_SWEEP,
    UOP_TEST
  } uop_t;

  // Sequencing rule of one microcode step
  typedef enum logic [1:0] {
    JMP_STEP,
    JMP_WHILE_BUSY,
    JMP_AXIS_LOOP
  } jmp_t;

  typedef struct packed {
    uop_t             op;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } uword_t;

  localparam logic [UPC_W-1:0] UPC_FROM  = UPC_W'(0);
  localparam logic [UPC_W-1:0] UPC_NEXT  = UPC_W'(1);
  localparam logic [UPC_W-1:0] UPC_AXIS  = UPC_W'(2);
  localparam logic [UPC_W-1:0] UPC_SWEEP = UPC_W'(3);
  localparam logic [UPC_W-1:0] UPC_TEST  = UPC_W'(4);

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic                    latch_prev;
    logic                    load_axis;
    logic                    corner_vld;
    logic [CORNER_IDX_W-1:0] corner_idx;
  } ctl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic busy;
    logic sep;
  } sts_t;

  // Program: per axis fetch edge start, fetch edge end, form axis,
  // sweep all corners through the projection pipe, then test intervals.
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
    uword_t w;
    unique case (upc)
      UPC_FROM:  w = '{op: UOP_FROM,  jmp: JMP_STEP,       target: UPC_FROM};
      UPC_NEXT:  w = '{op: UOP_NEXT,  jmp: JMP_STEP,       target: UPC_FROM};
      UPC_AXIS:  w = '{op: UOP_AXIS,  jmp: JMP_STEP,       target: UPC_FROM};
      UPC_SWEEP: w = '{op: UOP_SWEEP, jmp: JMP_WHILE_BUSY, target: UPC_SWEEP};
      UPC_TEST:  w = '{op: UOP_TEST,  jmp: JMP_AXIS_LOOP,  target: UPC_FROM};
      default:   w = '{op: UOP_TEST,  jmp: JMP_AXIS_LOOP,  target: UPC_FROM};
    endcase
    return w;
  endfunction

endpackage

// ----- src/rpsat_dp.sv -----
// ---------------------------------------------------------------------------
// rpsat_dp
// Axis former, projection pipe (two multipliers, adder) and interval tracker.
// ---------------------------------------------------------------------------
module rpsat_dp #(
  parameter int COORD_WIDTH = rpsat_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rpsat_pkg::ctl_t               ctl,
  input  logic signed [COORD_WIDTH-1:0] rd_x,
  input  logic signed [COORD_WIDTH-1:0] rd_y,
  output rpsat_pkg::sts_t               sts
);
  import rpsat_pkg::*;

  localparam int AW = COORD_WIDTH + 1;
  localparam int PW = COORD_WIDTH + AW;
  localparam int SW = PW + 1;

  logic signed [COORD_WIDTH-1:0] prev_x, prev_y;
  logic signed [AW-1:0] dx, dy, ax, ay;
  logic signed [PW-1:0] prod_p, prod_q;
  logic signed [SW-1:0] proj, lo0, hi0, lo1, hi1, cur_lo, cur_hi, new_lo, new_hi;
  logic v1, v2, s1, s2, f1, f2;

  assign dx = AW'(rd_x) - AW'(prev_x);
  assign dy = AW'(rd_y) - AW'(prev_y);

  always_comb begin
    cur_lo = s2 ? lo1 : lo0;
    cur_hi = s2 ? hi1 : hi0;
    new_lo = (f2 || (proj < cur_lo)) ? proj : cur_lo;
    new_hi = (f2 || (proj > cur_hi)) ? proj : cur_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.corner_vld;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_prev) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
    end
    if (ctl.load_axis) begin
      ax <= -dy;
      ay <= dx;
    end
    prod_p <= PW'(rd_x) * PW'(ax);
    prod_q <= PW'(rd_y) * PW'(ay);
    s1     <= ctl.corner_idx[CORNER_IDX_W-1];
    f1     <= (ctl.corner_idx[CORNER_IDX_W-2:0] == '0);
    proj   <= SW'(prod_p) + SW'(prod_q);
    s2     <= s1;
    f2     <= f1;
    if (v2) begin
      if (s2) begin
        lo1 <= new_lo;
        hi1 <= new_hi;
      end else begin
        lo0 <= new_lo;
        hi0 <= new_hi;
      end
    end
  end

  assign sts.busy = v1 || v2;
  assign sts.sep  = (hi0 < lo1) || (hi1 < lo0);

endmodule

// ----- src/rect_pair_separating_axis_test_unit.sv -----
// ---------------------------------------------------------------------------
// rect_pair_separating_axis_test_unit
// Overlap test of two rotated rectangles by separating axes, microcoded.
// ---------------------------------------------------------------------------
//   Input channel (in_valid/in_ready, corner_x, corner_y) takes one corner
//   word per handshake: four corners of the first rectangle in perimeter
//   order, then four of the second. Coordinates are signed Q11.4.
//   Output channel (out_valid/out_ready, overlap) delivers one word per
//   eight corners: 1 when the shapes overlap or touch, 0 when separated.
//   Corners are taken one per cycle while the sequencer is idle. After the
//   eighth the sequencer runs, per axis, edge fetch, axis forming, corner
//   sweep and interval test over up to four axes, stopping at the first
//   separating one. The corner memory has a single read port and the
//   datapath one multiplier pair.
//   in_ready is low while the sequencer runs. A result waiting on a stalled
//   receiver does not block corners of the next pair, but the eighth corner
//   is held off until that result is taken.
//   Reset clears the corner count, the sequencer and the output valid; the
//   corner memory keeps whatever it held.
// ---------------------------------------------------------------------------
`include "rect_pair_separating_axis_test_unit_macros.svh"
module rect_pair_separating_axis_test_unit #(
  parameter int COORD_WIDTH = rpsat_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] corner_x,
  input  logic signed [COORD_WIDTH-1:0] corner_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          overlap
);
  import rpsat_pkg::*;

  localparam int IDX_W = CORNER_IDX_W;
  localparam int CNT_W = IDX_W + 1;

  // Corner memory: one write port (load), one registered read port (edge fetch and sweep)
  logic [2*COORD_WIDTH-1:0] corner_mem [TOTAL_CORNERS];

  seq_state_t           state, state_next;
  logic [UPC_W-1:0]     upc, upc_next;
  logic [AXIS_W-1:0]    axis, axis_next;
  logic [CNT_W-1:0]     issue_cnt, issue_cnt_next;
  logic [IDX_W-1:0]     load_count;
  uword_t               uword;

  logic                 in_acc, last_corner, issue_pending, sweep_busy;
  logic                 rd_en, rd_sweep, run_done, result;
  logic [IDX_W-1:0]     from_addr, rd_addr, rd_idx;
  logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
  logic                 rd_vld;

  ctl_t                 ctl;
  sts_t                 sts;

  assign uword         = ucode_rom(upc);
  assign in_acc        = in_valid && in_ready;
  assign last_corner   = (load_count == IDX_W'(TOTAL_CORNERS - 1));
  assign issue_pending = (issue_cnt < CNT_W'(TOTAL_CORNERS));
  assign sweep_busy    = issue_pending || rd_vld || sts.busy;
  // First corner of the axis edge: shape base plus edge select
  assign from_addr     = IDX_W'(axis[AXIS_W-1] * SHAPE_CORNERS) + IDX_W'(axis[0]);

  // Sequencer next state
  always_comb begin
    state_next     = state;
    upc_next       = upc;
    axis_next      = axis;
    issue_cnt_next = issue_cnt;
    unique case (state)
      SEQ_IDLE: begin
        if (in_acc && last_corner) begin
          state_next = SEQ_RUN;
          upc_next   = UPC_FROM;
          axis_next  = '0;
        end
      end
      SEQ_RUN: begin
        unique case (uword.jmp)
          JMP_STEP:       upc_next = upc + 1'b1;
          JMP_WHILE_BUSY: upc_next = sweep_busy ? uword.target : upc + 1'b1;
          JMP_AXIS_LOOP: begin
            if (run_done) begin
              state_next = SEQ_IDLE;
            end else begin
              axis_next = axis + 1'b1;
              upc_next  = uword.target;
            end
          end
          default:        state_next = SEQ_IDLE;
        endcase
        if (uword.op == UOP_AXIS) begin
          issue_cnt_next = '0;
        end else if (rd_sweep) begin
          issue_cnt_next = issue_cnt + 1'b1;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs: decode the control word
  always_comb begin
    in_ready       = (state == SEQ_IDLE) && !(last_corner && out_valid);
    rd_en          = 1'b0;
    rd_sweep       = 1'b0;
    rd_addr        = from_addr;
    run_done       = 1'b0;
    result         = 1'b0;
    ctl.latch_prev = 1'b0;
    ctl.load_axis  = 1'b0;
    ctl.corner_vld = rd_vld;
    ctl.corner_idx = rd_idx;
    if (state == SEQ_RUN) begin
      unique case (uword.op)
        UOP_FROM: begin
          rd_en   = 1'b1;
          rd_addr = from_addr;
        end
        UOP_NEXT: begin
          rd_en          = 1'b1;
          rd_addr        = from_addr + 1'b1;
          ctl.latch_prev = 1'b1;
        end
        UOP_AXIS: ctl.load_axis = 1'b1;
        UOP_SWEEP: begin
          rd_en    = issue_pending;
          rd_sweep = issue_pending;
          rd_addr  = issue_cnt[IDX_W-1:0];
        end
        UOP_TEST: begin
          // stop at the first separating axis, or after the last one
          run_done = sts.sep || (axis == AXIS_W'(NUM_AXES - 1));
          result   = !sts.sep;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SEQ_IDLE;
      upc        <= UPC_FROM;
      axis       <= '0;
      issue_cnt  <= '0;
      load_count <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      upc       <= upc_next;
      axis      <= axis_next;
      issue_cnt <= issue_cnt_next;
      rd_vld    <= rd_sweep;
      if (in_acc) begin
        load_count <= load_count + 1'b1;
      end
      if (run_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Memory write on load, registered read for the sequencer; result word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      corner_mem[load_count] <= {corner_y, corner_x};
    end
    if (rd_en) begin
      {rd_y, rd_x} <= corner_mem[rd_addr];
      rd_idx       <= rd_addr;
    end
    if (run_done) begin
      overlap <= result;
    end
  end

  rpsat_dp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .rd_x (rd_x),
    .rd_y (rd_y),
    .sts  (sts)
  );

  // A run always starts right after the eighth corner, so the count is back at zero
  `RPSAT_ASSERT(a_run_load_zero, clk, rst, (state == SEQ_RUN) |-> (load_count == '0))
  // A run never starts while the previous result is still pending
  `RPSAT_NEVER(a_run_out_pending, clk, rst, (state == SEQ_RUN) && out_valid)
  // A result word only comes out of a run
  `RPSAT_ASSERT(a_result_from_run, clk, rst, $rose(out_valid) |-> $past(state == SEQ_RUN))
  // Sweep data only follows a sweep read
  `RPSAT_ASSERT(a_rd_from_sweep, clk, rst, rd_vld |-> $past(state == SEQ_RUN && uword.op == UOP_SWEEP))

endmodule
